// File: src/ssib_pkg.sv
package ssib_pkg;

    // Field and configuration widths
    localparam int RowW   = 30;
    localparam int SizeW  = 11;
    localparam int OffW   = 5;
    localparam int PlaneW = 2 * SizeW;
    localparam int NW     = 4;
    localparam int IdxW   = 32;

    // Divider depth: one quotient bit per stage
    localparam int DivSteps = RowW;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DEST_NX  = 3'd0,
        CFG_DEST_NY  = 3'd1,
        CFG_SRC_NX   = 3'd2,
        CFG_SRC_NY   = 3'd3,
        CFG_SRC_NZ   = 3'd4,
        CFG_X_OFFSET = 3'd5,
        CFG_Y_OFFSET = 3'd6,
        CFG_Z_OFFSET = 3'd7
    } cfg_idx_t;

    // Item fields that ride along with a division
    typedef struct packed {
        logic [RowW-1:0] kd;
        logic            left;
        logic [NW-1:0]   n;
    } side_t;

    // One axis after the limit checks
    typedef struct packed {
        logic signed [IdxW-1:0] idx;
        logic                   lo_ok;
        logic                   hi_ok;
    } axis_t;

    // Low check first, then high check on the possibly clamped index
    function automatic axis_t check_axis(input logic signed [IdxW-1:0] idx,
                                         input logic [SizeW-1:0] size,
                                         input logic signed [5:0] shift);
        axis_t r;
        logic signed [IdxW-1:0] lim_lo;
        logic signed [IdxW-1:0] lim_hi;
        lim_lo = 32'sd1 + IdxW'(shift);
        lim_hi = $signed({{(IdxW-SizeW){1'b0}}, size}) + IdxW'(shift);
        r.idx   = idx;
        r.lo_ok = 1'b1;
        r.hi_ok = 1'b1;
        if (r.idx < lim_lo) begin
            r.lo_ok = 1'b0;
            r.idx   = '0;
        end
        if (r.idx >= lim_hi) begin
            r.hi_ok = 1'b0;
            r.idx   = $signed({{(IdxW-SizeW){1'b0}}, size}) - 32'sd1;
        end
        return r;
    endfunction

endpackage

// File: src/ssib_div.sv
// Pipelined restoring divider, one quotient bit per stage, with stall chain.
module ssib_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ssib_pkg::RowW-1:0]    in_num,
    input  ssib_pkg::side_t              in_side,
    input  logic [ssib_pkg::PlaneW-1:0]  divisor,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ssib_pkg::RowW-1:0]    out_quo,
    output logic [ssib_pkg::PlaneW-1:0]  out_rem,
    output ssib_pkg::side_t              out_side
);

    localparam int N = ssib_pkg::DivSteps;
    localparam int W = ssib_pkg::RowW;
    localparam int R = ssib_pkg::PlaneW;

    logic                v_reg    [N];
    logic [W-1:0]        work_reg [N];
    logic [R-1:0]        rem_reg  [N];
    ssib_pkg::side_t     side_reg [N];
    logic                adv      [N];

    // Stall chain: a stage moves when empty or when the next one moves
    always_comb begin
        adv[N-1] = !v_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--) begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign in_ready = adv[0];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic [W-1:0]        w_in;
        logic [R-1:0]        r_in;
        ssib_pkg::side_t     s_in;
        logic                v_in;
        logic [R:0]          trial;
        logic                ge;
        logic [W-1:0]        work_next;
        logic [R-1:0]        rem_next;

        if (g == 0) begin : g_first
            assign w_in = in_num;
            assign r_in = '0;
            assign s_in = in_side;
            assign v_in = in_valid;
        end else begin : g_rest
            assign w_in = work_reg[g-1];
            assign r_in = rem_reg[g-1];
            assign s_in = side_reg[g-1];
            assign v_in = v_reg[g-1];
        end

        // Shift in the next dividend bit, subtract when it fits
        always_comb begin
            trial     = {r_in, w_in[W-1]};
            ge        = trial >= {1'b0, divisor};
            rem_next  = ge ? R'(trial - {1'b0, divisor}) : trial[R-1:0];
            work_next = {w_in[W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (adv[g]) begin
                v_reg[g] <= v_in;
            end
            if (adv[g]) begin
                work_reg[g] <= work_next;
                rem_reg[g]  <= rem_next;
                side_reg[g] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_quo   = work_reg[N-1];
    assign out_rem   = rem_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// File: src/stencil_source_index_bounds_unit.sv
// Channel  | Ports                                             | Dir
// ---------+---------------------------------------------------+-----
// input    | s_valid s_ready s_row_index s_stagger_left         | in
//          | s_stencil_entries                                 |
// result   | m_valid m_ready m_column_index m_lo_ok_mask        | out
//          | m_hi_ok_mask m_in_bounds_mask                      |
// config   | cfg_we cfg_index cfg_wdata                        | in
//
// One item per cycle when not stalled; two 30-stage bit-serial-per-stage
// dividers for the plane and row splits, then check, multiply, sum stages.
// Reset (aresetn low, synchronous) empties the pipeline and loads sizes 1,
// offsets 0. A stall on m_ready backs up only into stages that hold items;
// empty stages keep accepting. Config is taken whenever cfg_we is high.
module stencil_source_index_bounds_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [ssib_pkg::SizeW-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ssib_pkg::RowW-1:0]     s_row_index,
    input  logic                          s_stagger_left,
    input  logic [ssib_pkg::NW-1:0]       s_stencil_entries,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ssib_pkg::RowW-1:0]     m_column_index,
    output logic [2:0]                    m_lo_ok_mask,
    output logic [2:0]                    m_hi_ok_mask,
    output logic [2:0]                    m_in_bounds_mask
);

    localparam int SW = ssib_pkg::SizeW;
    localparam int OW = ssib_pkg::OffW;
    localparam int RW = ssib_pkg::RowW;
    localparam int PW = ssib_pkg::PlaneW;
    localparam int XW = ssib_pkg::IdxW;

    // Configuration registers
    logic [SW-1:0]        dnx_reg, dny_reg, snx_reg, sny_reg, snz_reg;
    logic signed [OW-1:0] xoff_reg, yoff_reg, zoff_reg;
    logic [PW-1:0]        dplane_reg, splane_reg;
    logic [SW-1:0]        wsize;

    assign wsize = (cfg_wdata == '0) ? SW'(1) : cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dnx_reg  <= SW'(1);
            dny_reg  <= SW'(1);
            snx_reg  <= SW'(1);
            sny_reg  <= SW'(1);
            snz_reg  <= SW'(1);
            xoff_reg <= '0;
            yoff_reg <= '0;
            zoff_reg <= '0;
        end else if (cfg_we) begin
            case (ssib_pkg::cfg_idx_t'(cfg_index))
                ssib_pkg::CFG_DEST_NX:  dnx_reg  <= wsize;
                ssib_pkg::CFG_DEST_NY:  dny_reg  <= wsize;
                ssib_pkg::CFG_SRC_NX:   snx_reg  <= wsize;
                ssib_pkg::CFG_SRC_NY:   sny_reg  <= wsize;
                ssib_pkg::CFG_SRC_NZ:   snz_reg  <= wsize;
                ssib_pkg::CFG_X_OFFSET: xoff_reg <= cfg_wdata[OW-1:0];
                ssib_pkg::CFG_Y_OFFSET: yoff_reg <= cfg_wdata[OW-1:0];
                ssib_pkg::CFG_Z_OFFSET: zoff_reg <= cfg_wdata[OW-1:0];
                default: ;
            endcase
        end
    end

    // Plane sizes, refreshed every cycle from the size registers
    always_ff @(posedge aclk) begin
        dplane_reg <= dnx_reg * dny_reg;
        splane_reg <= snx_reg * sny_reg;
    end

    // Stage handshake chain for the back end
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    assign adv3 = !v3_reg || m_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    // First split: row into plane index and remainder
    ssib_pkg::side_t     side_in, side1, side2;
    logic                d1_valid, d1_ready, d2_valid;
    logic [RW-1:0]       quo1, quo2;
    logic [PW-1:0]       rem1, rem2;

    always_comb begin
        side_in.kd   = '0;
        side_in.left = s_stagger_left;
        side_in.n    = s_stencil_entries;
    end

    ssib_div u_div_plane (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_num    (s_row_index),
        .in_side   (side_in),
        .divisor   (dplane_reg),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .out_quo   (quo1),
        .out_rem   (rem1),
        .out_side  (side1)
    );

    // Second split: remainder into y and x
    ssib_pkg::side_t side_mid;

    always_comb begin
        side_mid    = side1;
        side_mid.kd = quo1;
    end

    ssib_div u_div_row (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .in_num    ({{(RW-PW){1'b0}}, rem1}),
        .in_side   (side_mid),
        .divisor   ({{(PW-SW){1'b0}}, dnx_reg}),
        .out_valid (d2_valid),
        .out_ready (adv1),
        .out_quo   (quo2),
        .out_rem   (rem2),
        .out_side  (side2)
    );

    // Stage 1: source coordinates, stencil shift, limit checks
    logic [4:0]              half;
    logic                    dec;
    logic signed [5:0]       shift;
    logic signed [XW-1:0]    i_raw, j_raw, k_raw;
    ssib_pkg::axis_t         ax_x, ax_y, ax_z;
    logic signed [XW-1:0]    is_reg, js_reg, ks_reg;
    logic [2:0]              lo1_reg, hi1_reg;

    always_comb begin
        half  = ({1'b0, side2.n} + 5'd1) >> 1;
        dec   = !side2.n[0] && !side2.left;
        shift = 6'sd1 - $signed({1'b0, half}) - $signed({5'd0, dec});
        i_raw = $signed({{(XW-SW){1'b0}}, rem2[SW-1:0]}) + XW'(xoff_reg);
        j_raw = $signed({{(XW-SW){1'b0}}, quo2[SW-1:0]}) + XW'(yoff_reg);
        k_raw = $signed({{(XW-RW){1'b0}}, side2.kd}) + XW'(zoff_reg);
        ax_x  = ssib_pkg::check_axis(i_raw, snx_reg, shift);
        if (sny_reg > SW'(1)) begin
            ax_y = ssib_pkg::check_axis(j_raw, sny_reg, shift);
        end else begin
            ax_y = '{idx: '0, lo_ok: 1'b1, hi_ok: 1'b1};
        end
        if (snz_reg > SW'(1)) begin
            ax_z = ssib_pkg::check_axis(k_raw, snz_reg, shift);
        end else begin
            ax_z = '{idx: '0, lo_ok: 1'b1, hi_ok: 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= d2_valid;
        end
        if (adv1) begin
            is_reg  <= ax_x.idx;
            js_reg  <= ax_y.idx;
            ks_reg  <= ax_z.idx;
            lo1_reg <= {ax_z.lo_ok, ax_y.lo_ok, ax_x.lo_ok};
            hi1_reg <= {ax_z.hi_ok, ax_y.hi_ok, ax_x.hi_ok};
        end
    end

    // Stage 2: plane and row products, wrapped to the column width
    logic [RW+PW-1:0] prodk;
    logic [RW+SW-1:0] prodj;
    logic [RW-1:0]    pk_reg, pj_reg, pi_reg;
    logic [2:0]       lo2_reg, hi2_reg;

    assign prodk = ks_reg[RW-1:0] * splane_reg;
    assign prodj = js_reg[RW-1:0] * snx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
        if (adv2) begin
            pk_reg  <= prodk[RW-1:0];
            pj_reg  <= prodj[RW-1:0];
            pi_reg  <= is_reg[RW-1:0];
            lo2_reg <= lo1_reg;
            hi2_reg <= hi1_reg;
        end
    end

    // Stage 3: column sum and output register
    logic [RW-1:0] col_reg;
    logic [2:0]    lo3_reg, hi3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv3) begin
            v3_reg <= v2_reg;
        end
        if (adv3) begin
            col_reg <= pk_reg + pj_reg + pi_reg;
            lo3_reg <= lo2_reg;
            hi3_reg <= hi2_reg;
        end
    end

    assign m_valid          = v3_reg;
    assign m_column_index   = col_reg;
    assign m_lo_ok_mask     = lo3_reg;
    assign m_hi_ok_mask     = hi3_reg;
    assign m_in_bounds_mask = lo3_reg & hi3_reg;

endmodule

// File: src/ssib_checker.sv
// Port-level checks on the result channel.
module ssib_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [ssib_pkg::RowW-1:0]  m_column_index,
    input logic [2:0]                 m_lo_ok_mask,
    input logic [2:0]                 m_hi_ok_mask,
    input logic [2:0]                 m_in_bounds_mask
);

    // A stalled item keeps its column
    a_hold_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_column_index))
        else $error("column changed under stall");

    // A stalled item keeps its masks
    a_hold_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_lo_ok_mask) && $stable(m_hi_ok_mask))
        else $error("masks changed under stall");

    // Combined mask is the AND of the low and high masks
    a_and_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_in_bounds_mask == (m_lo_ok_mask & m_hi_ok_mask))
        else $error("in-bounds mask mismatch");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("item present after reset");

endmodule

bind stencil_source_index_bounds_unit ssib_checker u_ssib_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_column_index   (m_column_index),
    .m_lo_ok_mask     (m_lo_ok_mask),
    .m_hi_ok_mask     (m_hi_ok_mask),
    .m_in_bounds_mask (m_in_bounds_mask)
);
